// ===== hw/rtl/csga_pkg.sv =====
`default_nettype none

package csga_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned SPEED_W   = FRAC_BITS + 1;
  localparam int unsigned VEL_W     = FRAC_BITS + 2;
  localparam int unsigned STATE_W   = 3;

  localparam logic [SPEED_W-1:0] SPEED_RST  = 17'd3277;
  localparam logic [SPEED_W-1:0] THRESH_RST = 17'd1311;

  localparam logic REG_SPEED  = 1'b0;
  localparam logic REG_THRESH = 1'b1;

  typedef enum logic [STATE_W-1:0] {
    CS_INITIAL = 3'd0,
    CS_READY   = 3'd1,
    CS_MOVING  = 3'd2,
    CS_INVALID = 3'd3,
    CS_DONE    = 3'd4
  } ctrl_state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/csga_in_if.sv =====
`default_nettype none

interface csga_in_if
  import csga_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [COORD_WIDTH-1:0] cur_x;
  logic signed [COORD_WIDTH-1:0] cur_y;
  logic signed [COORD_WIDTH-1:0] cur_z;
  logic signed [COORD_WIDTH-1:0] goal_x;
  logic signed [COORD_WIDTH-1:0] goal_y;
  logic signed [COORD_WIDTH-1:0] goal_z;
  logic [STATE_W-1:0]            new_state;

  modport source (
    output valid, mode, cur_x, cur_y, cur_z, goal_x, goal_y, goal_z, new_state,
    input  ready
  );
  modport sink (
    input  valid, mode, cur_x, cur_y, cur_z, goal_x, goal_y, goal_z, new_state,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/csga_out_if.sv =====
`default_nettype none

interface csga_out_if
  import csga_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [VEL_W-1:0] vel_x;
  logic signed [VEL_W-1:0] vel_y;
  logic signed [VEL_W-1:0] vel_z;
  logic [STATE_W-1:0]      state_now;
  logic [STATE_W-1:0]      state_before;

  modport source (
    output valid, vel_x, vel_y, vel_z, state_now, state_before,
    input  ready
  );
  modport sink (
    input  valid, vel_x, vel_y, vel_z, state_now, state_before,
    output ready
  );
endinterface

`default_nettype wire

// ===== hw/rtl/constant_speed_goal_approach_unit.sv =====
`default_nettype none

// Constant-speed goal approach controller. Each step beat carries current and goal positions
// (signed, FRAC_BITS fraction bits); the result beat carries the commanded velocity and the
// controller state after and before the most recent change. One item is in work at a time, and
// the input is taken again once the result sits in the output register. A force beat, or a
// control beat in the initial, invalid-goal or done state, goes from F_IDLE straight to F_OUT,
// which loads the output register once it is free. A control beat in ready or moving runs
// bit-serially through one shared shift-add multiplier, a restoring square root and a
// restoring divider. The three squares, the root and the three speed products and quotients
// all go one after another through these units, one bit a cycle; once the goal is reached
// (root below the threshold), the speed products and quotients are skipped.
module constant_speed_goal_approach_unit
  import csga_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire                 cfg_idx_i,
  input  wire [SPEED_W-1:0]   cfg_data_i,
  csga_in_if.sink             step_i,
  csga_out_if.source          res_o
);

  localparam int unsigned DW   = COORD_WIDTH + 1;
  localparam int unsigned NW   = DW + SPEED_W + 1;
  localparam int unsigned AW   = (2 * DW > NW) ? 2 * DW : NW;
  localparam int unsigned QW   = FRAC_BITS + 2;
  localparam int unsigned VXW  = (QW + 1 > VEL_W) ? QW + 1 : VEL_W;
  localparam int unsigned CNTW = $clog2(NW + 1);
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  typedef enum logic [3:0] {
    F_IDLE, F_ABS, F_LD, F_SQ, F_SUM, F_ROOT, F_CHK,
    F_SPL, F_SPD, F_NUM, F_DIV, F_VEL, F_OUT
  } fsm_e;

  fsm_e              fsm_q;
  ctrl_state_e       ctrl_q, prior_q;
  logic [SPEED_W-1:0] speed_q, thresh_q;
  logic              mode_q;
  logic [STATE_W-1:0] new_state_q;
  logic [DW-1:0]     d_q [3];
  logic [2:0]        neg_q;
  logic [1:0]        k_q;
  logic [CNTW-1:0]   cnt_q;
  logic [DW-1:0]     mpl_q;
  logic [AW-1:0]     acc_q;
  logic [2*DW-1:0]   sum_q;
  logic [DW+1:0]     rem_q;
  logic [DW-1:0]     root_q;
  logic [NW-1:0]     num_q;
  logic [QW-1:0]     quo_q;
  logic              ovf_q;
  logic [VEL_W-1:0]  vel_q [3];
  logic              arrive_q;

  logic              ov_q;
  logic [VEL_W-1:0]  ovel_q [3];
  logic [STATE_W-1:0] onow_q, obef_q;

  logic [DW-1:0]     mag_cur;
  logic [AW-1:0]     acc_step;
  logic [DW+1:0]     rt_sh, rt_try;
  logic              rt_ge;
  logic [DW:0]       dv_sh;
  logic              dv_ge;
  logic              big;
  logic [QW-1:0]     qsat;
  logic [VXW-1:0]    vmag, vsig;
  ctrl_state_e       nxt_st;
  logic              chg;
  logic              push;
  logic              acc_in;

  assign mag_cur  = d_q[k_q];
  assign acc_step = {acc_q[AW-2:0], 1'b0} + (mpl_q[DW-1] ? AW'(mag_cur) : '0);

  assign rt_sh  = {rem_q[DW-1:0], sum_q[2*DW-1 -: 2]};
  assign rt_try = {root_q, 2'b01};
  assign rt_ge  = rt_sh >= rt_try;

  assign dv_sh = {rem_q[DW-1:0], num_q[NW-1]};
  assign dv_ge = dv_sh >= {1'b0, root_q};

  assign big  = ovf_q || (quo_q > ONE_Q);
  assign qsat = big ? ONE_Q : quo_q;
  assign vmag = VXW'(qsat);
  assign vsig = neg_q[k_q] ? -vmag : vmag;

  always_comb begin
    nxt_st = ctrl_q;
    if (mode_q) begin
      if (new_state_q <= STATE_W'(CS_DONE)) nxt_st = ctrl_state_e'(new_state_q);
    end else if (ctrl_q == CS_READY || ctrl_q == CS_MOVING) begin
      nxt_st = arrive_q ? CS_DONE : CS_MOVING;
    end
  end

  assign chg    = nxt_st != ctrl_q;
  assign push   = (fsm_q == F_OUT) && (!ov_q || res_o.ready);
  assign acc_in = step_i.valid && step_i.ready;

  assign step_i.ready       = fsm_q == F_IDLE;
  assign res_o.valid        = ov_q;
  assign res_o.vel_x        = ovel_q[0];
  assign res_o.vel_y        = ovel_q[1];
  assign res_o.vel_z        = ovel_q[2];
  assign res_o.state_now    = onow_q;
  assign res_o.state_before = obef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= F_IDLE;
      ctrl_q      <= CS_INITIAL;
      prior_q     <= CS_INITIAL;
      speed_q     <= SPEED_RST;
      thresh_q    <= THRESH_RST;
      mode_q      <= 1'b0;
      new_state_q <= '0;
      d_q         <= '{default: '0};
      neg_q       <= '0;
      k_q         <= '0;
      cnt_q       <= '0;
      mpl_q       <= '0;
      acc_q       <= '0;
      sum_q       <= '0;
      rem_q       <= '0;
      root_q      <= '0;
      num_q       <= '0;
      quo_q       <= '0;
      ovf_q       <= 1'b0;
      vel_q       <= '{default: '0};
      arrive_q    <= 1'b0;
      ov_q        <= 1'b0;
      ovel_q      <= '{default: '0};
      onow_q      <= '0;
      obef_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        priority if (cfg_idx_i == REG_SPEED) speed_q <= cfg_data_i;
        else thresh_q <= cfg_data_i;
      end

      ov_q <= push || (ov_q && !res_o.ready);

      unique case (fsm_q)
        F_IDLE: begin
          if (acc_in) begin
            mode_q      <= step_i.mode;
            new_state_q <= step_i.new_state;
            d_q[0] <= {step_i.goal_x[COORD_WIDTH-1], step_i.goal_x}
                    - {step_i.cur_x[COORD_WIDTH-1], step_i.cur_x};
            d_q[1] <= {step_i.goal_y[COORD_WIDTH-1], step_i.goal_y}
                    - {step_i.cur_y[COORD_WIDTH-1], step_i.cur_y};
            d_q[2] <= {step_i.goal_z[COORD_WIDTH-1], step_i.goal_z}
                    - {step_i.cur_z[COORD_WIDTH-1], step_i.cur_z};
            vel_q    <= '{default: '0};
            arrive_q <= 1'b0;
            if (!step_i.mode && (ctrl_q == CS_READY || ctrl_q == CS_MOVING)) begin
              fsm_q <= F_ABS;
            end else begin
              fsm_q <= F_OUT;
            end
          end
        end
        F_ABS: begin
          for (int i = 0; i < 3; i++) begin
            neg_q[i] <= d_q[i][DW-1];
            d_q[i]   <= d_q[i][DW-1] ? -d_q[i] : d_q[i];
          end
          sum_q <= '0;
          k_q   <= '0;
          fsm_q <= F_LD;
        end
        F_LD: begin
          acc_q <= '0;
          mpl_q <= mag_cur;
          cnt_q <= CNTW'(DW);
          fsm_q <= F_SQ;
        end
        F_SQ: begin
          acc_q <= acc_step;
          mpl_q <= mpl_q << 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNTW'(1)) fsm_q <= F_SUM;
        end
        F_SUM: begin
          sum_q <= sum_q + acc_q[2*DW-1:0];
          if (k_q == 2'd2) begin
            k_q    <= '0;
            rem_q  <= '0;
            root_q <= '0;
            cnt_q  <= CNTW'(DW);
            fsm_q  <= F_ROOT;
          end else begin
            k_q   <= k_q + 1'b1;
            fsm_q <= F_LD;
          end
        end
        F_ROOT: begin
          sum_q  <= sum_q << 2;
          rem_q  <= rt_ge ? rt_sh - rt_try : rt_sh;
          root_q <= {root_q[DW-2:0], rt_ge};
          cnt_q  <= cnt_q - 1'b1;
          if (cnt_q == CNTW'(1)) fsm_q <= F_CHK;
        end
        F_CHK: begin
          k_q <= '0;
          if (root_q < DW'(thresh_q)) begin
            arrive_q <= 1'b1;
            fsm_q    <= F_OUT;
          end else if (root_q == '0) begin
            fsm_q <= F_OUT;
          end else begin
            fsm_q <= F_SPL;
          end
        end
        F_SPL: begin
          acc_q <= '0;
          mpl_q <= DW'(speed_q) << (DW - SPEED_W);
          cnt_q <= CNTW'(SPEED_W);
          fsm_q <= F_SPD;
        end
        F_SPD: begin
          acc_q <= acc_step;
          mpl_q <= mpl_q << 1;
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNTW'(1)) fsm_q <= F_NUM;
        end
        F_NUM: begin
          num_q <= acc_q[NW-1:0] + NW'(root_q >> 1);
          rem_q <= '0;
          quo_q <= '0;
          ovf_q <= 1'b0;
          cnt_q <= CNTW'(NW);
          fsm_q <= F_DIV;
        end
        F_DIV: begin
          num_q <= num_q << 1;
          rem_q <= (DW + 2)'(dv_ge ? dv_sh - {1'b0, root_q} : dv_sh);
          quo_q <= {quo_q[QW-2:0], dv_ge};
          ovf_q <= ovf_q | quo_q[QW-1];
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNTW'(1)) fsm_q <= F_VEL;
        end
        F_VEL: begin
          vel_q[k_q] <= vsig[VEL_W-1:0];
          if (k_q == 2'd2) begin
            fsm_q <= F_OUT;
          end else begin
            k_q   <= k_q + 1'b1;
            fsm_q <= F_SPL;
          end
        end
        F_OUT: begin
          if (push) begin
            ovel_q <= vel_q;
            onow_q <= nxt_st;
            obef_q <= chg ? ctrl_q : prior_q;
            if (chg) begin
              prior_q <= ctrl_q;
              ctrl_q  <= nxt_st;
            end
            fsm_q <= F_IDLE;
          end
        end
        default: fsm_q <= F_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_prior_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_q != prior_q) || (ctrl_q == CS_INITIAL && prior_q == CS_INITIAL))
    else $error("prior state equals current state after a change");

  a_state_on_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(ctrl_q) |-> $past(push))
    else $error("controller state changed without a result beat");

  a_vel_only_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.vel_x != '0 || res_o.vel_y != '0 || res_o.vel_z != '0))
    |-> (res_o.state_now == STATE_W'(CS_MOVING)))
    else $error("nonzero velocity outside moving state");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_in |=> (fsm_q != F_IDLE))
    else $error("sequencer idle right after taking a beat");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
module tb
  import csga_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned FRAC_W  = FRAC_BITS;
  localparam int unsigned LIMIT   = 2_000_000;
  localparam logic [127:0] ONE    = 128'd1 << FRAC_W;

  typedef struct {
    logic                      mode;
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic signed [COORD_W-1:0] gx, gy, gz;
    logic [STATE_W-1:0]        nst;
  } step_t;

  typedef struct {
    logic signed [VEL_W-1:0] vx, vy, vz;
    logic [STATE_W-1:0]      now, was;
  } motion_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [SPEED_W-1:0] cfg_data_i;

  csga_in_if #(.COORD_WIDTH(COORD_W)) step_if ();
  csga_out_if res_if ();

  constant_speed_goal_approach_unit #(
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .step_i    (step_if),
    .res_o     (res_if)
  );

  step_t              step_q[$];
  motion_t            motion_q[$];
  logic [SPEED_W-1:0] speed_reg;
  logic [SPEED_W-1:0] thresh_reg;
  logic [STATE_W-1:0] ctrl_st;
  logic [STATE_W-1:0] prev_st;
  int unsigned        mismatch_cnt = 0;
  int unsigned        cycle_cnt = 0;
  int unsigned        gap_left = 0;
  int unsigned        calm_tx = 0;
  int unsigned        stall_left = 0;
  int unsigned        calm_rx = 0;
  bit                 step_busy = 1'b0;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // ---------------- predictor ----------------

  function automatic void change_state(input logic [STATE_W-1:0] nxt);
    if (nxt != ctrl_st) begin
      prev_st = ctrl_st;
      ctrl_st = nxt;
    end
  endfunction

  function automatic logic [127:0] root_floor(input logic [127:0] s);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [VEL_W-1:0] axis_vel(input logic signed [COORD_W+1:0] d,
                                                       input logic [127:0] len);
    logic [COORD_W+1:0]      mag;
    logic [127:0]            q;
    logic signed [VEL_W-1:0] v;
    mag = d[COORD_W+1] ? -d : d;
    q = (128'(mag) * 128'(speed_reg) + (len >> 1)) / len;
    if (q > ONE) q = ONE;
    v = q[VEL_W-1:0];
    return d[COORD_W+1] ? -v : v;
  endfunction

  function automatic motion_t predict_motion(input step_t s);
    motion_t                   m;
    logic signed [COORD_W+1:0] d [3];
    logic [COORD_W+1:0]        a;
    logic [127:0]              sq;
    logic [127:0]              len;
    m.vx = '0;
    m.vy = '0;
    m.vz = '0;
    if (s.mode) begin
      if (s.nst <= CS_DONE) change_state(s.nst);
    end else if (ctrl_st == CS_READY || ctrl_st == CS_MOVING) begin
      d[0] = {{2{s.gx[COORD_W-1]}}, s.gx} - {{2{s.cx[COORD_W-1]}}, s.cx};
      d[1] = {{2{s.gy[COORD_W-1]}}, s.gy} - {{2{s.cy[COORD_W-1]}}, s.cy};
      d[2] = {{2{s.gz[COORD_W-1]}}, s.gz} - {{2{s.cz[COORD_W-1]}}, s.cz};
      sq = '0;
      for (int i = 0; i < 3; i++) begin
        a = d[i][COORD_W+1] ? -d[i] : d[i];
        sq += 128'(a) * 128'(a);
      end
      len = root_floor(sq);
      if (len < 128'(thresh_reg)) begin
        change_state(CS_DONE);
      end else begin
        change_state(CS_MOVING);
        if (len != 0) begin
          m.vx = axis_vel(d[0], len);
          m.vy = axis_vel(d[1], len);
          m.vz = axis_vel(d[2], len);
        end
      end
    end
    m.now = ctrl_st;
    m.was = prev_st;
    return m;
  endfunction

  // ---------------- stimulus ----------------

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  function automatic logic [COORD_W-1:0] jitter(input int unsigned span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic step_t random_step(input bit force_item);
    step_t       s;
    int unsigned span;
    s.mode = force_item;
    s.cx   = $urandom;
    s.cy   = $urandom;
    s.cz   = $urandom;
    s.gx   = $urandom;
    s.gy   = $urandom;
    s.gz   = $urandom;
    s.nst  = STATE_W'($urandom_range(0, (1 << STATE_W) - 1));
    if (!force_item) begin
      case ($urandom_range(0, 9))
        0, 1, 2: span = 800;
        3, 4:    span = 1 << 18;
        5, 6:    span = 1 << 28;
        7:       span = 0;
        default: span = 32'hFFFF_FFFF;
      endcase
      // otherwise the goal stays fully independent of the position
      if (span != 32'hFFFF_FFFF) begin
        s.gx = s.cx + jitter(span);
        s.gy = s.cy + jitter(span);
        s.gz = s.cz + jitter(span);
      end
    end
    return s;
  endfunction

  function automatic void push_force(input logic [STATE_W-1:0] st);
    step_t s;
    s = random_step(1'b1);
    s.nst = st;
    step_q.push_back(s);
  endfunction

  function automatic void push_ctrl(input logic [COORD_W-1:0] cx, cy, cz, gx, gy, gz);
    step_t s;
    s = random_step(1'b0);
    s.cx = cx;
    s.cy = cy;
    s.cz = cz;
    s.gx = gx;
    s.gy = gy;
    s.gz = gz;
    step_q.push_back(s);
  endfunction

  task automatic run_random(input int unsigned n);
    int unsigned cnt;
    int unsigned k;
    step_t       s;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 9) < 8) begin
        push_force($urandom_range(0, 1) ? CS_MOVING : CS_READY);
        k = $urandom_range(3, 12);
        repeat (k) step_q.push_back(random_step(1'b0));
        cnt += k + 1;
      end else begin
        s = random_step(1'($urandom_range(0, 1)));
        step_q.push_back(s);
        if (!(s.mode && s.nst > CS_DONE)) cnt++;
      end
    end
  endtask

  task automatic settle();
    while (step_q.size() != 0 || motion_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [SPEED_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == REG_SPEED) speed_reg = val;
    else thresh_reg = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------- checking ----------------

  task automatic flag_error(input string msg);
    if (mismatch_cnt < 100) $display("tb: error: %s", msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input logic [VEL_W-1:0] got,
                             input logic [VEL_W-1:0] want);
    if (got !== want) flag_error($sformatf("%s got %h expected %h", name, got, want));
  endtask

  // ---------------- step driver ----------------

  always @(negedge clk_i) begin
    if (!step_busy) begin
      if (gap_left != 0) begin
        gap_left--;
        step_if.valid <= 1'b0;
      end else if (step_q.size() != 0) begin
        step_if.valid     <= 1'b1;
        step_if.mode      <= step_q[0].mode;
        step_if.cur_x     <= step_q[0].cx;
        step_if.cur_y     <= step_q[0].cy;
        step_if.cur_z     <= step_q[0].cz;
        step_if.goal_x    <= step_q[0].gx;
        step_if.goal_y    <= step_q[0].gy;
        step_if.goal_z    <= step_q[0].gz;
        step_if.new_state <= step_q[0].nst;
        step_busy = 1'b1;
        if (calm_tx != 0) begin
          calm_tx--;
          gap_left = 0;
        end else begin
          gap_left = idle_len();
          if ($urandom_range(0, 39) == 0) calm_tx = $urandom_range(10, 30);
        end
      end else begin
        step_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (step_if.valid && step_if.ready) begin
      motion_q.push_back(predict_motion(step_q.pop_front()));
      step_busy = 1'b0;
    end
  end

  // ---------------- result side ----------------

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
      if (calm_rx != 0) calm_rx--;
      else if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      if ($urandom_range(0, 199) == 0) calm_rx = $urandom_range(50, 400);
    end
  end

  always @(posedge clk_i) begin : watch_results
    motion_t want;
    if (res_if.valid && res_if.ready) begin
      if (motion_q.size() == 0) begin
        flag_error("result beat with no step pending");
      end else begin
        want = motion_q.pop_front();
        check_field("vel_x", res_if.vel_x, want.vx);
        check_field("vel_y", res_if.vel_y, want.vy);
        check_field("vel_z", res_if.vel_z, want.vz);
        check_field("state_now", VEL_W'(res_if.state_now), VEL_W'(want.now));
        check_field("state_before", VEL_W'(res_if.state_before), VEL_W'(want.was));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // ---------------- sequence ----------------

  initial begin
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = REG_SPEED;
    cfg_data_i        = '0;
    step_if.valid     = 1'b0;
    step_if.mode      = 1'b0;
    step_if.cur_x     = '0;
    step_if.cur_y     = '0;
    step_if.cur_z     = '0;
    step_if.goal_x    = '0;
    step_if.goal_y    = '0;
    step_if.goal_z    = '0;
    step_if.new_state = '0;
    res_if.ready      = 1'b0;
    speed_reg         = SPEED_RST;
    thresh_reg        = THRESH_RST;
    ctrl_st           = CS_INITIAL;
    prev_st           = CS_INITIAL;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: state walk and geometry corners
    push_ctrl('0, '0, '0, 32'h0001_0000, '0, '0);
    push_force(CS_READY);
    push_force(CS_READY);
    push_ctrl(32'h1234_5678, 32'hFEDC_BA98, '0, 32'h1234_5678, 32'hFEDC_BA98, '0);
    push_ctrl('0, '0, '0, 32'h7FFF_FFFF, '0, '0);
    push_force(CS_INVALID);
    push_ctrl('0, '0, '0, 32'h7FFF_FFFF, '0, '0);
    for (int s = CS_DONE + 1; s < (1 << STATE_W); s++) push_force(STATE_W'(s));
    push_force(CS_MOVING);
    push_ctrl(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_ctrl(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_ctrl('0, '0, '0, 32'h0001_0000, '0, '0);
    push_ctrl('0, '0, '0, '0, 32'hFFFF_0000, '0);
    push_ctrl('0, '0, '0, '0, '0, 32'd1311);
    push_ctrl('0, '0, '0, '0, '0, 32'd1310);
    push_force(CS_INITIAL);
    push_force(CS_DONE);
    push_force(CS_READY);
    push_ctrl(32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000,
              32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_8000);
    run_random(60);
    settle();

    // zero speed, zero threshold: zero-length step stays moving
    write_reg(REG_SPEED, '0);
    write_reg(REG_THRESH, '0);
    push_force(CS_MOVING);
    push_ctrl(32'h0000_4000, 32'hC000_0000, 32'h0000_0001,
              32'h0000_4000, 32'hC000_0000, 32'h0000_0001);
    push_ctrl('0, '0, '0, 32'h0005_0000, 32'hFFFB_0000, '0);
    run_random(100);
    settle();

    write_reg(REG_SPEED, 17'h1_0000);
    write_reg(REG_THRESH, 17'h1_0000);
    run_random(120);
    settle();

    // speed above 1.0 saturates the components
    write_reg(REG_SPEED, '1);
    write_reg(REG_THRESH, THRESH_RST);
    push_force(CS_MOVING);
    push_ctrl('0, '0, '0, 32'h0010_0000, '0, '0);
    push_ctrl('0, '0, '0, '0, '0, 32'hFFF0_0000);
    run_random(120);
    settle();

    repeat (4) begin
      write_reg(REG_SPEED, SPEED_W'($urandom_range(0, 65536)));
      write_reg(REG_THRESH, SPEED_W'($urandom_range(0, 1) ? $urandom_range(0, 4096)
                                                           : $urandom_range(0, 65536)));
      run_random(100);
      settle();
    end

    repeat (50) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
